FILE: rtl/lab_to_lch_pixel_top_defines.svh
// Assertion macros shared by the LCh conversion block.
// Define ASSERT_OFF to compile every check away.
`ifndef LAB_TO_LCH_PIXEL_TOP_DEFINES_SVH
`define LAB_TO_LCH_PIXEL_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define LAB2LCH_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lab2lch: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LAB2LCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lab2lch: next-cycle check failed");

`else

`define LAB2LCH_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define LAB2LCH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/lab2lch_pkg.sv
`default_nettype none

package lab2lch_pkg;

    localparam int ANGLE_STEPS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int LIGHT_W   = 15;
    localparam int AXIS_W    = 16;
    localparam int CHROMA_W  = 16;
    localparam int HUE_W     = 15;
    localparam int SQ_W      = 32;

    localparam int GUARD_BITS   = 24;
    localparam int TABLE_BITS   = 24;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_W     = AXIS_W + GUARD_BITS + 3;
    localparam int ANGLE_HEAD_W = 17;
    localparam int ROOT_STEPS   = 16;

    localparam int HUE_FULL      = 23040;
    localparam int HUE_HALF_TURN = 11520;
    localparam int HUE_UP        = 5760;
    localparam int HUE_DOWN      = 17280;

    typedef struct packed {
        logic eol;
        logic a_zero;
        logic b_neg;
        logic b_zero;
    } flags_t;

    // atan(2^-i) in degrees, scaled by 2^24.
    localparam longint ATAN_DEG [TABLE_LEN] = '{
        64'sd754974720, 64'sd445687602, 64'sd235489088, 64'sd119537938,
        64'sd60000934,  64'sd30029717,  64'sd15018523,  64'sd7509720,
        64'sd3754917,   64'sd1877466,   64'sd938734,    64'sd469367,
        64'sd234684,    64'sd117342,    64'sd58671,     64'sd29335,
        64'sd14668,     64'sd7334,      64'sd3667,      64'sd1833,
        64'sd917,       64'sd458,       64'sd229,       64'sd115
    };

    // Step angle in units of 2^-(6+frac_bits) degree, rounded half up.
    function automatic longint step_angle(input int idx, input int frac_bits);
        longint t;
        int     sh;
        t  = 64'sd0;
        sh = TABLE_BITS - 6 - frac_bits;
        if (idx >= 0 && idx < TABLE_LEN) begin
            t = ATAN_DEG[idx];
            if (sh > 0) begin
                t = (t + (64'sd1 <<< (sh - 1))) >>> sh;
            end
            else begin
                t = t <<< (-sh);
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lab2lch_front.sv
`default_nettype none

module lab2lch_front #(
    parameter int FRACTION_BITS = lab2lch_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        up_valid,
    output logic                                             up_stall,
    input  wire logic        [lab2lch_pkg::LIGHT_W-1:0]      up_lightness,
    input  wire logic signed [lab2lch_pkg::AXIS_W-1:0]       up_a,
    input  wire logic signed [lab2lch_pkg::AXIS_W-1:0]       up_b,
    input  wire logic                                        up_eol,
    output logic                                             dn_valid,
    input  wire logic                                        dn_stall,
    output logic signed [lab2lch_pkg::CORDIC_W-1:0]          dn_x,
    output logic signed [lab2lch_pkg::CORDIC_W-1:0]          dn_y,
    output logic signed [FRACTION_BITS+lab2lch_pkg::ANGLE_HEAD_W-1:0] dn_z,
    output logic        [lab2lch_pkg::CHROMA_W-1:0]          dn_root,
    output logic        [lab2lch_pkg::SQ_W-1:0]              dn_rest,
    output logic        [lab2lch_pkg::LIGHT_W-1:0]           dn_lightness,
    output lab2lch_pkg::flags_t                              dn_flags
);

    localparam int ZW = FRACTION_BITS + lab2lch_pkg::ANGLE_HEAD_W;
    localparam int XW = lab2lch_pkg::CORDIC_W;
    localparam int EXT_W = XW - (lab2lch_pkg::AXIS_W + 1) - lab2lch_pkg::GUARD_BITS;
    localparam logic signed [ZW-1:0] BASE_HALF =
        ZW'(longint'(lab2lch_pkg::HUE_HALF_TURN) <<< FRACTION_BITS);

    logic                                   valid_reg;
    logic signed [XW-1:0]                   x_reg, x_next;
    logic signed [XW-1:0]                   y_reg, y_next;
    logic signed [ZW-1:0]                   z_reg, z_next;
    logic [lab2lch_pkg::SQ_W-1:0]           rest_reg, rest_next;
    logic [lab2lch_pkg::LIGHT_W-1:0]        lightness_reg;
    lab2lch_pkg::flags_t                    flags_reg, flags_next;

    logic signed [lab2lch_pkg::AXIS_W:0]    a_ext, b_ext, x_start, y_start;
    logic signed [lab2lch_pkg::SQ_W-1:0]    a_sq, b_sq;
    logic                                   load;

    assign up_stall = valid_reg && dn_stall;
    assign load     = up_valid && !up_stall;

    always_comb
    begin
        a_ext = {up_a[lab2lch_pkg::AXIS_W-1], up_a};
        b_ext = {up_b[lab2lch_pkg::AXIS_W-1], up_b};
        if (up_a[lab2lch_pkg::AXIS_W-1])
        begin
            x_start = -a_ext;
            y_start = -b_ext;
            z_next  = BASE_HALF;
        end
        else
        begin
            x_start = a_ext;
            y_start = b_ext;
            z_next  = '0;
        end
        x_next = {{EXT_W{x_start[lab2lch_pkg::AXIS_W]}}, x_start,
                  {lab2lch_pkg::GUARD_BITS{1'b0}}};
        y_next = {{EXT_W{y_start[lab2lch_pkg::AXIS_W]}}, y_start,
                  {lab2lch_pkg::GUARD_BITS{1'b0}}};
        a_sq      = lab2lch_pkg::SQ_W'(up_a) * lab2lch_pkg::SQ_W'(up_a);
        b_sq      = lab2lch_pkg::SQ_W'(up_b) * lab2lch_pkg::SQ_W'(up_b);
        rest_next = lab2lch_pkg::SQ_W'(a_sq) + lab2lch_pkg::SQ_W'(b_sq);
        flags_next.eol    = up_eol;
        flags_next.a_zero = (up_a == '0);
        flags_next.b_neg  = up_b[lab2lch_pkg::AXIS_W-1];
        flags_next.b_zero = (up_b == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            rest_reg      <= rest_next;
            lightness_reg <= up_lightness;
            flags_reg     <= flags_next;
        end
    end

    assign dn_valid     = valid_reg;
    assign dn_x         = x_reg;
    assign dn_y         = y_reg;
    assign dn_z         = z_reg;
    assign dn_root      = '0;
    assign dn_rest      = rest_reg;
    assign dn_lightness = lightness_reg;
    assign dn_flags     = flags_reg;

endmodule

`default_nettype wire

FILE: rtl/lab2lch_cell.sv
`default_nettype none

module lab2lch_cell #(
    parameter int CELL_INDEX    = 0,
    parameter int ANGLE_STEPS   = lab2lch_pkg::ANGLE_STEPS_DEF,
    parameter int FRACTION_BITS = lab2lch_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        up_valid,
    output logic                                             up_stall,
    input  wire logic signed [lab2lch_pkg::CORDIC_W-1:0]     up_x,
    input  wire logic signed [lab2lch_pkg::CORDIC_W-1:0]     up_y,
    input  wire logic signed [FRACTION_BITS+lab2lch_pkg::ANGLE_HEAD_W-1:0] up_z,
    input  wire logic        [lab2lch_pkg::CHROMA_W-1:0]     up_root,
    input  wire logic        [lab2lch_pkg::SQ_W-1:0]         up_rest,
    input  wire logic        [lab2lch_pkg::LIGHT_W-1:0]      up_lightness,
    input  wire lab2lch_pkg::flags_t                         up_flags,
    output logic                                             dn_valid,
    input  wire logic                                        dn_stall,
    output logic signed [lab2lch_pkg::CORDIC_W-1:0]          dn_x,
    output logic signed [lab2lch_pkg::CORDIC_W-1:0]          dn_y,
    output logic signed [FRACTION_BITS+lab2lch_pkg::ANGLE_HEAD_W-1:0] dn_z,
    output logic        [lab2lch_pkg::CHROMA_W-1:0]          dn_root,
    output logic        [lab2lch_pkg::SQ_W-1:0]              dn_rest,
    output logic        [lab2lch_pkg::LIGHT_W-1:0]           dn_lightness,
    output lab2lch_pkg::flags_t                              dn_flags
);

    localparam int ZW = FRACTION_BITS + lab2lch_pkg::ANGLE_HEAD_W;
    localparam int XW = lab2lch_pkg::CORDIC_W;
    localparam int RW = lab2lch_pkg::CHROMA_W;
    localparam int SW = lab2lch_pkg::SQ_W;
    localparam bit DO_ROT  = (CELL_INDEX < ANGLE_STEPS) &&
                             (CELL_INDEX < lab2lch_pkg::TABLE_LEN);
    localparam bit DO_ROOT = CELL_INDEX < lab2lch_pkg::ROOT_STEPS;
    localparam int ROT_K   = DO_ROT ? CELL_INDEX : 0;
    localparam int ROOT_K  = DO_ROOT ? (lab2lch_pkg::ROOT_STEPS - 1 - CELL_INDEX) : 0;
    localparam logic signed [ZW-1:0] STEP =
        ZW'(lab2lch_pkg::step_angle(CELL_INDEX, FRACTION_BITS));

    logic                               valid_reg;
    logic signed [XW-1:0]               x_reg, x_next;
    logic signed [XW-1:0]               y_reg, y_next;
    logic signed [ZW-1:0]               z_reg, z_next;
    logic [RW-1:0]                      root_reg, root_next;
    logic [SW-1:0]                      rest_reg, rest_next;
    logic [lab2lch_pkg::LIGHT_W-1:0]    lightness_reg;
    lab2lch_pkg::flags_t                flags_reg;

    logic signed [XW-1:0]               dx, dy;
    logic [SW:0]                        trial;
    logic                               load;

    assign up_stall = valid_reg && dn_stall;
    assign load     = up_valid && !up_stall;

    always_comb
    begin
        dx        = up_x >>> ROT_K;
        dy        = up_y >>> ROT_K;
        x_next    = up_x;
        y_next    = up_y;
        z_next    = up_z;
        root_next = up_root;
        rest_next = up_rest;
        trial     = ((SW + 1)'(up_root) << (ROOT_K + 1)) + ((SW + 1)'(1) << (2 * ROOT_K));
        if (DO_ROT)
        begin
            if (!up_y[XW-1])
            begin
                x_next = up_x + dy;
                y_next = up_y - dx;
                z_next = up_z + STEP;
            end
            else
            begin
                x_next = up_x - dy;
                y_next = up_y + dx;
                z_next = up_z - STEP;
            end
        end
        if (DO_ROOT)
        begin
            if ({1'b0, up_rest} >= trial)
            begin
                rest_next = SW'({1'b0, up_rest} - trial);
                root_next = up_root | (RW'(1) << ROOT_K);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            root_reg      <= root_next;
            rest_reg      <= rest_next;
            lightness_reg <= up_lightness;
            flags_reg     <= up_flags;
        end
    end

    assign dn_valid     = valid_reg;
    assign dn_x         = x_reg;
    assign dn_y         = y_reg;
    assign dn_z         = z_reg;
    assign dn_root      = root_reg;
    assign dn_rest      = rest_reg;
    assign dn_lightness = lightness_reg;
    assign dn_flags     = flags_reg;

endmodule

`default_nettype wire

FILE: rtl/lab2lch_back.sv
`default_nettype none

module lab2lch_back #(
    parameter int FRACTION_BITS = lab2lch_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        up_valid,
    output logic                                             up_stall,
    input  wire logic signed [FRACTION_BITS+lab2lch_pkg::ANGLE_HEAD_W-1:0] up_z,
    input  wire logic        [lab2lch_pkg::CHROMA_W-1:0]     up_root,
    input  wire logic        [lab2lch_pkg::SQ_W-1:0]         up_rest,
    input  wire logic        [lab2lch_pkg::LIGHT_W-1:0]      up_lightness,
    input  wire lab2lch_pkg::flags_t                         up_flags,
    output logic                                             dn_valid,
    input  wire logic                                        dn_stall,
    output logic        [lab2lch_pkg::LIGHT_W-1:0]           dn_lightness,
    output logic        [lab2lch_pkg::CHROMA_W-1:0]          dn_chroma,
    output logic        [lab2lch_pkg::HUE_W-1:0]             dn_hue,
    output logic                                             dn_eol
);

    localparam int ZW = FRACTION_BITS + lab2lch_pkg::ANGLE_HEAD_W;
    localparam int HW = lab2lch_pkg::HUE_W;
    localparam int RW = lab2lch_pkg::CHROMA_W;
    localparam logic signed [ZW-1:0] FULL_TURN =
        ZW'(longint'(lab2lch_pkg::HUE_FULL) <<< FRACTION_BITS);
    localparam logic signed [ZW-1:0] ROUND_HALF =
        ZW'(longint'(1) <<< (FRACTION_BITS - 1));

    logic                               valid_reg;
    logic [lab2lch_pkg::LIGHT_W-1:0]    lightness_reg;
    logic [RW-1:0]                      chroma_reg, chroma_next;
    logic [HW-1:0]                      hue_reg, hue_next;
    logic                               eol_reg;

    logic signed [ZW-1:0]               wrapped, rounded;
    logic [HW-1:0]                      hue_angle;
    logic                               load;

    assign up_stall = valid_reg && dn_stall;
    assign load     = up_valid && !up_stall;

    always_comb
    begin
        priority if (up_z < 0)
        begin
            wrapped = up_z + FULL_TURN;
        end
        else if (up_z >= FULL_TURN)
        begin
            wrapped = up_z - FULL_TURN;
        end
        else
        begin
            wrapped = up_z;
        end
        rounded   = (wrapped + ROUND_HALF) >>> FRACTION_BITS;
        hue_angle = HW'(rounded);
        if (hue_angle >= HW'(lab2lch_pkg::HUE_FULL))
        begin
            hue_angle = '0;
        end

        priority if (!up_flags.a_zero)
        begin
            hue_next = hue_angle;
        end
        else if (up_flags.b_neg)
        begin
            hue_next = HW'(lab2lch_pkg::HUE_DOWN);
        end
        else if (up_flags.b_zero)
        begin
            hue_next = '0;
        end
        else
        begin
            hue_next = HW'(lab2lch_pkg::HUE_UP);
        end

        chroma_next = up_root + RW'(up_rest > lab2lch_pkg::SQ_W'(up_root));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lightness_reg <= up_lightness;
            chroma_reg    <= chroma_next;
            hue_reg       <= hue_next;
            eol_reg       <= up_flags.eol;
        end
    end

    assign dn_valid     = valid_reg;
    assign dn_lightness = lightness_reg;
    assign dn_chroma    = chroma_reg;
    assign dn_hue       = hue_reg;
    assign dn_eol       = eol_reg;

endmodule

`default_nettype wire

FILE: rtl/lab_to_lch_pixel_top.sv
// Converts a stream of CIE Lab pixels to LCh, one pixel per clock.
// Input channel: pixel_valid, pixel_stall and the fields lightness, a_axis,
// b_axis and end_of_line. Output channel: lch_valid, lch_stall and the
// fields lightness_out, chroma, hue and end_of_line_out. An item moves at a
// rising edge where valid is high and stall is low.
// Lightness and the end-of-line flag pass through unchanged. Chroma is the
// rounded square root of a*a + b*b in Q8.8, and hue is in 1/64 degree.
// The pipeline has one entry stage that forms the squares, one cell per
// step of the chain (each cell does at most one angle rotation and one
// root digit), and one output stage that wraps and rounds the hue.
// Throughput is one item per clock unless stalled. Each stage holds its
// item while the next one is full and stalled, so empty stages keep
// filling while the receiver stalls; pixel_stall rises only when every
// stage is occupied. Reset clears all valid flags; no item is lost or
// repeated across a stall.
`default_nettype none

`include "lab_to_lch_pixel_top_defines.svh"

module lab_to_lch_pixel_top #(
    parameter int ANGLE_STEPS   = lab2lch_pkg::ANGLE_STEPS_DEF,
    parameter int FRACTION_BITS = lab2lch_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   pixel_valid,
    output logic                                        pixel_stall,
    input  wire logic        [lab2lch_pkg::LIGHT_W-1:0] lightness,
    input  wire logic signed [lab2lch_pkg::AXIS_W-1:0]  a_axis,
    input  wire logic signed [lab2lch_pkg::AXIS_W-1:0]  b_axis,
    input  wire logic                                   end_of_line,
    output logic                                        lch_valid,
    input  wire logic                                   lch_stall,
    output logic        [lab2lch_pkg::LIGHT_W-1:0]      lightness_out,
    output logic        [lab2lch_pkg::CHROMA_W-1:0]     chroma,
    output logic        [lab2lch_pkg::HUE_W-1:0]        hue,
    output logic                                        end_of_line_out
);

    localparam int ZW = FRACTION_BITS + lab2lch_pkg::ANGLE_HEAD_W;
    localparam int XW = lab2lch_pkg::CORDIC_W;
    localparam int NUM_CELLS = (ANGLE_STEPS > lab2lch_pkg::ROOT_STEPS) ?
                               ANGLE_STEPS : lab2lch_pkg::ROOT_STEPS;
    localparam logic [lab2lch_pkg::HUE_W-1:0] HUE_LIMIT =
        lab2lch_pkg::HUE_W'(lab2lch_pkg::HUE_FULL);
    localparam logic [lab2lch_pkg::CHROMA_W-1:0] CHROMA_MAX =
        lab2lch_pkg::CHROMA_W'(46341);

    logic                                   valid_chain     [NUM_CELLS+1];
    logic                                   stall_chain     [NUM_CELLS+1];
    logic signed [XW-1:0]                   x_chain         [NUM_CELLS+1];
    logic signed [XW-1:0]                   y_chain         [NUM_CELLS+1];
    logic signed [ZW-1:0]                   z_chain         [NUM_CELLS+1];
    logic [lab2lch_pkg::CHROMA_W-1:0]       root_chain      [NUM_CELLS+1];
    logic [lab2lch_pkg::SQ_W-1:0]           rest_chain      [NUM_CELLS+1];
    logic [lab2lch_pkg::LIGHT_W-1:0]        lightness_chain [NUM_CELLS+1];
    lab2lch_pkg::flags_t                    flags_chain     [NUM_CELLS+1];

    lab2lch_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (pixel_valid),
        .up_stall     (pixel_stall),
        .up_lightness (lightness),
        .up_a         (a_axis),
        .up_b         (b_axis),
        .up_eol       (end_of_line),
        .dn_valid     (valid_chain[0]),
        .dn_stall     (stall_chain[0]),
        .dn_x         (x_chain[0]),
        .dn_y         (y_chain[0]),
        .dn_z         (z_chain[0]),
        .dn_root      (root_chain[0]),
        .dn_rest      (rest_chain[0]),
        .dn_lightness (lightness_chain[0]),
        .dn_flags     (flags_chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        lab2lch_cell #(
            .CELL_INDEX    (i),
            .ANGLE_STEPS   (ANGLE_STEPS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .up_valid     (valid_chain[i]),
            .up_stall     (stall_chain[i]),
            .up_x         (x_chain[i]),
            .up_y         (y_chain[i]),
            .up_z         (z_chain[i]),
            .up_root      (root_chain[i]),
            .up_rest      (rest_chain[i]),
            .up_lightness (lightness_chain[i]),
            .up_flags     (flags_chain[i]),
            .dn_valid     (valid_chain[i+1]),
            .dn_stall     (stall_chain[i+1]),
            .dn_x         (x_chain[i+1]),
            .dn_y         (y_chain[i+1]),
            .dn_z         (z_chain[i+1]),
            .dn_root      (root_chain[i+1]),
            .dn_rest      (rest_chain[i+1]),
            .dn_lightness (lightness_chain[i+1]),
            .dn_flags     (flags_chain[i+1])
        );
    end

    lab2lch_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (valid_chain[NUM_CELLS]),
        .up_stall     (stall_chain[NUM_CELLS]),
        .up_z         (z_chain[NUM_CELLS]),
        .up_root      (root_chain[NUM_CELLS]),
        .up_rest      (rest_chain[NUM_CELLS]),
        .up_lightness (lightness_chain[NUM_CELLS]),
        .up_flags     (flags_chain[NUM_CELLS]),
        .dn_valid     (lch_valid),
        .dn_stall     (lch_stall),
        .dn_lightness (lightness_out),
        .dn_chroma    (chroma),
        .dn_hue       (hue),
        .dn_eol       (end_of_line_out)
    );

    `LAB2LCH_ASSERT_HOLDS(hue_below_full_turn_a, clk, rst_n, lch_valid, hue < HUE_LIMIT)
    `LAB2LCH_ASSERT_HOLDS(chroma_in_range_a, clk, rst_n, lch_valid, chroma <= CHROMA_MAX)
    `LAB2LCH_ASSERT_HOLDS(stall_only_when_full_a, clk, rst_n, pixel_stall, lch_valid && lch_stall)
    `LAB2LCH_ASSERT_NEXT(accept_fills_entry_a, clk, rst_n, pixel_valid && !pixel_stall, valid_chain[0])

endmodule

`default_nettype wire
